FILE: rtl/core/q2e_pkg.sv
package q2e_pkg;

  localparam int unsigned VecW      = 37;  // CORDIC x/y datapath
  localparam int unsigned AngW      = 34;  // angle, units of pi/2^31
  localparam int unsigned SumW      = 34;  // doubled product sums
  localparam int unsigned SqW       = 63;  // square root remainder/root
  localparam int unsigned SqrtSteps = 31;  // one root bit per cell
  localparam int unsigned AtanLen   = 25;

  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [AngW-1:0] ang;
    logic                   skip;  // angle already final
  } vec_t;

  typedef struct packed {
    logic signed [SumW-1:0] yn;
    logic signed [SumW-1:0] yd;
    logic signed [SumW-1:0] rn;
    logic signed [SumW-1:0] rd;
    logic signed [31:0]     s;
    logic                   sat;
  } side_t;

  localparam logic signed [AngW-1:0] AngPi     = AngW'(64'sh8000_0000);
  localparam logic signed [AngW-1:0] AngHalfPi = AngW'(64'sh4000_0000);

  function automatic logic signed [AngW-1:0] atan_entry(input int unsigned idx);
    logic [31:0] v;
    begin
      unique case (idx)
        0:  v = 32'h20000000;  1:  v = 32'h12E4051D;  2:  v = 32'h09FB385B;
        3:  v = 32'h051111D4;  4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
        6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;  8:  v = 32'h0028BE53;
        9:  v = 32'h00145F2E;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
        12: v = 32'h00028BE6;  13: v = 32'h000145F3;  14: v = 32'h0000A2F9;
        15: v = 32'h0000517C;  16: v = 32'h000028BE;  17: v = 32'h0000145F;
        18: v = 32'h00000A2F;  19: v = 32'h00000517;  20: v = 32'h0000028B;
        21: v = 32'h00000145;  22: v = 32'h000000A2;  23: v = 32'h00000051;
        24: v = 32'h00000028;
        default: v = 32'h0;
      endcase
      atan_entry = AngW'(signed'({1'b0, v}));
    end
  endfunction

  // Special cases and left-half-plane turn ahead of the rotation cells.
  function automatic vec_t prep(input logic signed [VecW-1:0] y,
                                input logic signed [VecW-1:0] x);
    vec_t r;
    begin
      r.x    = x;
      r.y    = y;
      r.ang  = '0;
      r.skip = 1'b0;
      if (x == '0) begin
        r.skip = 1'b1;
        if (y > 0)      r.ang = AngHalfPi;
        else if (y < 0) r.ang = -AngHalfPi;
      end else if (y == '0) begin
        r.skip = 1'b1;
        if (x < 0) r.ang = AngPi;
      end else if (x < 0) begin
        r.ang = (y > 0) ? AngPi : -AngPi;
        r.x   = -x;
        r.y   = -y;
      end
      prep = r;
    end
  endfunction

endpackage

FILE: rtl/core/quaternion_to_euler.sv
// Stages: 3 product/sum stages, 31 root cells, 1 prep, the CORDIC rotation
//   cells and 1 output register.
// Throughput: one word per cycle; the whole pipe advances unless a result
//   waits in the output register under stall_i.
// Reset: rst_ni clears all valid flags; the pipe comes out empty.
module quaternion_to_euler #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [15:0] yaw_angle_o,
  output logic signed [15:0] pitch_angle_o,
  output logic signed [15:0] roll_angle_o,
  output logic               pitch_saturated_o
);

  localparam int unsigned SumW = q2e_pkg::SumW;
  localparam int unsigned SqW  = q2e_pkg::SqW;
  localparam int unsigned VecW = q2e_pkg::VecW;
  localparam int unsigned AngW = q2e_pkg::AngW;
  localparam int unsigned NSq  = q2e_pkg::SqrtSteps;

  logic adv;
  logic out_vld_q;

  assign adv     = !out_vld_q || !stall_i;
  assign stall_o = !adv;

  // stage 1: products
  logic               v1_q;
  logic signed [31:0] p_wz_q, p_xy_q, p_ww_q, p_xx_q, p_wx_q, p_yz_q, p_zz_q, p_wy_q, p_xz_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_wz_q <= quat_w_i * quat_z_i;
      p_xy_q <= quat_x_i * quat_y_i;
      p_ww_q <= quat_w_i * quat_w_i;
      p_xx_q <= quat_x_i * quat_x_i;
      p_wx_q <= quat_w_i * quat_x_i;
      p_yz_q <= quat_y_i * quat_z_i;
      p_zz_q <= quat_z_i * quat_z_i;
      p_wy_q <= quat_w_i * quat_y_i;
      p_xz_q <= quat_x_i * quat_z_i;
    end
  end

  // stage 2: doubled sums, arcsine clamp
  localparam logic signed [SumW-1:0] OneQ30 = SumW'(64'sh4000_0000);

  logic                   v2_q;
  q2e_pkg::side_t         side2_d, side2_q;
  logic signed [SumW-1:0] s_raw;

  always_comb begin
    side2_d.yn = (SumW'(p_wz_q) + SumW'(p_xy_q)) <<< 1;
    side2_d.yd = ((SumW'(p_ww_q) + SumW'(p_xx_q)) <<< 1) - OneQ30;
    side2_d.rn = (SumW'(p_wx_q) + SumW'(p_yz_q)) <<< 1;
    side2_d.rd = ((SumW'(p_ww_q) + SumW'(p_zz_q)) <<< 1) - OneQ30;
    s_raw      = (SumW'(p_wy_q) - SumW'(p_xz_q)) <<< 1;
    side2_d.sat = 1'b0;
    side2_d.s   = 32'(s_raw);
    if (s_raw > OneQ30) begin
      side2_d.s   = 32'(OneQ30);
      side2_d.sat = 1'b1;
    end else if (s_raw < -OneQ30) begin
      side2_d.s   = 32'(-OneQ30);
      side2_d.sat = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) side2_q <= side2_d;
  end

  // stage 3: radicand 2^60 - s^2
  logic               v3_q;
  logic signed [63:0] s_sq;
  logic [SqW-1:0]     rad_q;
  q2e_pkg::side_t     side3_q;

  assign s_sq = side2_q.s * side2_q.s;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rad_q   <= (SqW'(1) << 60) - SqW'(s_sq[60:0]);
      side3_q <= side2_q;
    end
  end

  // square root cells, one root bit each
  logic           sq_vld  [NSq+1];
  logic [SqW-1:0] sq_rem  [NSq+1];
  logic [SqW-1:0] sq_root [NSq+1];
  q2e_pkg::side_t sq_side [NSq+1];

  assign sq_vld[0]  = v3_q;
  assign sq_rem[0]  = rad_q;
  assign sq_root[0] = '0;
  assign sq_side[0] = side3_q;

  for (genvar j = 0; j < NSq; j++) begin : g_sqrt
    q2e_sqrt_cell #(.K(NSq - 1 - j)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (sq_vld[j]),
      .rem_i   (sq_rem[j]),
      .root_i  (sq_root[j]),
      .side_i  (sq_side[j]),
      .valid_o (sq_vld[j+1]),
      .rem_o   (sq_rem[j+1]),
      .root_o  (sq_root[j+1]),
      .side_o  (sq_side[j+1])
    );
  end

  // prep stage
  logic                vp_q;
  q2e_pkg::vec_t [2:0] vp_vec_q;
  logic                vp_sat_q;
  q2e_pkg::side_t      sd;

  assign sd = sq_side[NSq];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vp_vec_q[0] <= q2e_pkg::prep(VecW'(sd.yn), VecW'(sd.yd));
      vp_vec_q[1] <= q2e_pkg::prep(VecW'(sd.s),
                                   signed'(VecW'(sq_root[NSq][30:0])));
      vp_vec_q[2] <= q2e_pkg::prep(VecW'(sd.rn), VecW'(sd.rd));
      vp_sat_q    <= sd.sat;
    end
  end

  // rotation cells
  logic                cr_vld [CORDIC_STEPS+1];
  q2e_pkg::vec_t [2:0] cr_vec [CORDIC_STEPS+1];
  logic                cr_sat [CORDIC_STEPS+1];

  assign cr_vld[0] = vp_q;
  assign cr_vec[0] = vp_vec_q;
  assign cr_sat[0] = vp_sat_q;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    q2e_cordic_cell #(.SHIFT(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (cr_vld[i]),
      .vec_i   (cr_vec[i]),
      .sat_i   (cr_sat[i]),
      .valid_o (cr_vld[i+1]),
      .vec_o   (cr_vec[i+1]),
      .sat_o   (cr_sat[i+1])
    );
  end

  // output register, round half up to pi/2^15
  logic signed [AngW:0] rnd [3];
  logic signed [15:0]   yaw_q, pitch_q, roll_q;
  logic                 sat_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rnd[k] = ((AngW + 1)'(cr_vec[CORDIC_STEPS][k].ang) + (AngW + 1)'(32768)) >>> 16;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      yaw_q   <= rnd[0][15:0];
      pitch_q <= rnd[1][15:0];
      roll_q  <= rnd[2][15:0];
      sat_q   <= cr_sat[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      vp_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      v1_q      <= valid_i;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      vp_q      <= sq_vld[NSq];
      out_vld_q <= cr_vld[CORDIC_STEPS];
    end
  end

  assign valid_o           = out_vld_q;
  assign yaw_angle_o       = yaw_q;
  assign pitch_angle_o     = pitch_q;
  assign roll_angle_o      = roll_q;
  assign pitch_saturated_o = sat_q;

  // a clamped arcsine lands exactly on a pole
  a_sat_pole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && sat_q |-> pitch_q == 16'sd16384 || pitch_q == -16'sd16384)
    else $error("saturated pitch not at pole");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> pitch_q <= 16'sd16384 && pitch_q >= -16'sd16384)
    else $error("pitch out of range");

  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> !stall_o)
    else $error("stall with empty output register");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |=> $stable(vp_vec_q) && $stable(rad_q))
    else $error("pipe moved while stalled");

endmodule

FILE: rtl/core/q2e_sqrt_cell.sv
module q2e_sqrt_cell #(
  parameter int unsigned K = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [q2e_pkg::SqW-1:0]     rem_i,
  input  logic [q2e_pkg::SqW-1:0]     root_i,
  input  q2e_pkg::side_t              side_i,
  output logic                        valid_o,
  output logic [q2e_pkg::SqW-1:0]     rem_o,
  output logic [q2e_pkg::SqW-1:0]     root_o,
  output q2e_pkg::side_t              side_o
);

  localparam logic [q2e_pkg::SqW-1:0] Bit = q2e_pkg::SqW'(1) << (2 * K);

  logic [q2e_pkg::SqW-1:0] trial;
  logic [q2e_pkg::SqW-1:0] rem_d, root_d;
  logic                    valid_q;
  logic [q2e_pkg::SqW-1:0] rem_q, root_q;
  q2e_pkg::side_t          side_q;

  assign trial = root_i + Bit;

  always_comb begin
    if (rem_i >= trial) begin
      rem_d  = rem_i - trial;
      root_d = (root_i >> 1) + Bit;
    end else begin
      rem_d  = rem_i;
      root_d = root_i >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule

FILE: rtl/core/q2e_cordic_cell.sv
module q2e_cordic_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  q2e_pkg::vec_t [2:0]   vec_i,
  input  logic                  sat_i,
  output logic                  valid_o,
  output q2e_pkg::vec_t [2:0]   vec_o,
  output logic                  sat_o
);

  localparam logic signed [q2e_pkg::AngW-1:0] Atan = q2e_pkg::atan_entry(SHIFT);

  q2e_pkg::vec_t [2:0] vec_d, vec_q;
  logic                valid_q, sat_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vec_d[i] = vec_i[i];
      if (!vec_i[i].skip) begin
        if (!vec_i[i].y[q2e_pkg::VecW-1]) begin
          vec_d[i].x   = vec_i[i].x + (vec_i[i].y >>> SHIFT);
          vec_d[i].y   = vec_i[i].y - (vec_i[i].x >>> SHIFT);
          vec_d[i].ang = vec_i[i].ang + Atan;
        end else begin
          vec_d[i].x   = vec_i[i].x - (vec_i[i].y >>> SHIFT);
          vec_d[i].y   = vec_i[i].y + (vec_i[i].x >>> SHIFT);
          vec_d[i].ang = vec_i[i].ang - Atan;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q <= vec_d;
      sat_q <= sat_i;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;
  assign sat_o   = sat_q;

endmodule

FILE: dv/tb_quaternion_to_euler.sv
module tb_quaternion_to_euler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Steps     = 16;
  localparam int unsigned Latency   = Steps + 36;
  localparam int unsigned NumRandom = 1200;
  localparam int unsigned IdleLimit = 20000;

  typedef struct {
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic               sat;
  } euler_t;

  class euler_scoreboard;
    euler_t pending[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    static function longint floor_shr(longint v, int unsigned s);
      return v >>> s;
    endfunction

    static function longint atan_step(int unsigned i);
      longint t[25] = '{
        64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
        64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
        64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028};
      return t[i];
    endfunction

    // four-quadrant angle, units of pi/2^31
    static function longint vector_angle(longint yv, longint xv);
      longint a, dx, dy;
      a = 0;
      if (xv == 0) return yv > 0 ? 64'sh40000000 : (yv < 0 ? -64'sh40000000 : 0);
      if (yv == 0) return xv > 0 ? 0 : 64'sh80000000;
      if (xv < 0) begin
        a  = yv > 0 ? 64'sh80000000 : -64'sh80000000;
        xv = -xv;
        yv = -yv;
      end
      for (int unsigned i = 0; i < Steps && i < 25; i++) begin
        dx = floor_shr(yv, i);
        dy = floor_shr(xv, i);
        if (yv >= 0) begin
          xv += dx; yv -= dy; a += atan_step(i);
        end else begin
          xv -= dx; yv += dy; a -= atan_step(i);
        end
      end
      return a;
    endfunction

    static function logic signed [15:0] to_binary_angle(longint a);
      longint r;
      r = floor_shr(a + 32768, 16);
      return r[15:0];
    endfunction

    static function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned rem, root, b;
      rem = v; root = 0; b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (rem >= root + b) begin
          rem -= root + b;
          root = (root >> 1) + b;
        end else begin
          root >>= 1;
        end
        b >>= 2;
      end
      return root;
    endfunction

    function void note_quat(logic signed [15:0] qw, logic signed [15:0] qx,
                            logic signed [15:0] qy, logic signed [15:0] qz);
      longint w, x, y, z, yn, yd, rn, rd, s, one;
      longint unsigned c;
      euler_t e;
      w = qw; x = qx; y = qy; z = qz;
      one = 64'sd1 << 30;
      yn = 2 * (w * z + x * y);
      yd = 2 * (w * w + x * x) - one;
      rn = 2 * (w * x + y * z);
      rd = 2 * (w * w + z * z) - one;
      s  = 2 * (w * y - x * z);
      e.sat = 1'b0;
      if (s > one) begin s = one; e.sat = 1'b1; end
      if (s < -one) begin s = -one; e.sat = 1'b1; end
      c = int_sqrt((64'd1 << 60) - longint'(s * s));
      e.yaw   = to_binary_angle(vector_angle(yn, yd));
      e.pitch = to_binary_angle(vector_angle(s, longint'(c)));
      e.roll  = to_binary_angle(vector_angle(rn, rd));
      pending.push_back(e);
    endfunction

    function void check_angles(euler_t act);
      euler_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word yaw=%0d pitch=%0d roll=%0d sat=%0b",
                 $time, act.yaw, act.pitch, act.roll, act.sat);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (act.yaw !== e.yaw) begin
        $display("%0t: yaw expected %0d actual %0d", $time, e.yaw, act.yaw);
        errors++;
      end
      if (act.pitch !== e.pitch) begin
        $display("%0t: pitch expected %0d actual %0d", $time, e.pitch, act.pitch);
        errors++;
      end
      if (act.roll !== e.roll) begin
        $display("%0t: roll expected %0d actual %0d", $time, e.roll, act.roll);
        errors++;
      end
      if (act.sat !== e.sat) begin
        $display("%0t: sat expected %0b actual %0b", $time, e.sat, act.sat);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  logic signed [15:0] quat_w_i = '0, quat_x_i = '0, quat_y_i = '0, quat_z_i = '0;
  logic stall_o, valid_o, pitch_saturated_o;
  logic signed [15:0] yaw_angle_o, pitch_angle_o, roll_angle_o;

  euler_scoreboard sb = new();
  bit sending_done = 0;
  bit hold_long = 0;
  int unsigned idle_cycles = 0;

  always #4 clk_i = ~clk_i;

  quaternion_to_euler #(.CORDIC_STEPS(Steps)) i_dut (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .quat_w_i, .quat_x_i, .quat_y_i, .quat_z_i,
    .valid_o, .stall_i,
    .yaw_angle_o, .pitch_angle_o, .roll_angle_o, .pitch_saturated_o
  );

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // random unit-ish quaternion: mostly near-normalized, some raw noise
  function automatic logic [63:0] random_quat();
    logic [63:0] q;
    int unsigned k;
    q = {$urandom, $urandom};
    k = $urandom_range(0, 9);
    if (k < 6) begin
      // shrink to roughly half scale so the norm stays near one
      q[63:48] = $signed(q[63:48]) >>> 1;
      q[47:32] = $signed(q[47:32]) >>> 1;
      q[31:16] = $signed(q[31:16]) >>> 1;
      q[15:0]  = $signed(q[15:0]) >>> 1;
    end else if (k < 8) begin
      q[31:0] = {16'(int'($urandom_range(0, 200)) - 100), 16'(int'($urandom_range(0, 200)) - 100)};
    end
    return q;
  endfunction

  task automatic send_quat(logic [63:0] q);
    valid_i  <= 1'b1;
    {quat_w_i, quat_x_i, quat_y_i, quat_z_i} <= q;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    sb.note_quat(q[63:48], q[47:32], q[31:16], q[15:0]);
  endtask

  task automatic idle_sender(int unsigned n);
    if (n == 0) return;
    valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  initial begin
    logic [63:0] directed[$];
    directed = '{
      64'h7FFF_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0000,
      64'h0000_7FFF_0000_0000, 64'h0000_0000_7FFF_0000, 64'h0000_0000_0000_7FFF,
      64'h8000_8000_8000_8000, 64'h7FFF_7FFF_7FFF_7FFF, 64'h5A82_0000_5A82_0000,
      64'h5A82_0000_A57E_0000, 64'h5A82_5A82_0000_0000, 64'h5A82_0000_0000_5A82,
      64'h0000_5A82_0000_5A82, 64'h0000_8000_0000_0000, 64'h7FFF_0000_7FFF_0000,
      64'h7FFF_0000_8000_0000, 64'h4000_4000_4000_4000, 64'hC000_4000_C000_4000,
      64'h0001_FFFF_0001_FFFF, 64'h5A82_A57E_0000_0000, 64'h0000_0000_5A82_5A82,
      64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_FFFF_0001_0000};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_quat(directed[i]);
    for (int unsigned n = 0; n < NumRandom; n++) begin
      if (n == 300) hold_long = 1;
      if (n == 500) begin
        // let the pipe drain completely
        valid_i <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk_i);
      end
      send_quat(random_quat());
      if (n < 200 || n >= 700) idle_sender(gap_len());
    end
    valid_i <= 1'b0;
    sending_done = 1;
  end

  // receiver stalls, one long hold-off while the sender keeps going
  initial begin
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      if (hold_long) begin
        hold_long = 0;
        stall_i <= 1'b1;
        repeat (200) @(posedge clk_i);
      end
      n = gap_len();
      if ($urandom_range(0, 3) == 0) n = 0;
      stall_i <= (n != 0);
      repeat (n == 0 ? 1 : n) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    euler_t got;
    if (rst_ni && valid_o && !stall_i) begin
      got.yaw = yaw_angle_o; got.pitch = pitch_angle_o;
      got.roll = roll_angle_o; got.sat = pitch_saturated_o;
      sb.check_angles(got);
    end
  end

  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (sending_done);
    while (sb.pending.size() != 0 && idle_cycles < IdleLimit) @(posedge clk_i);
    if (idle_cycles >= IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      repeat (Latency + 10) @(posedge clk_i);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
        $display("Regression PASS");
      end else begin
        $display("Regression FAIL");
      end
      $finish;
    end
  end

  initial begin
    wait (idle_cycles >= IdleLimit);
    if (!sending_done) begin
      $display("Regression FAIL");
      $finish;
    end
  end
endmodule

FILE: files.f
rtl/core/q2e_pkg.sv
rtl/core/q2e_sqrt_cell.sv
rtl/core/q2e_cordic_cell.sv
rtl/core/quaternion_to_euler.sv
dv/tb_quaternion_to_euler.sv
